[hdl/csp_pkg.sv]
// Shared types and constants for the cubic spline evaluator.
// Used by every module in this folder; no dependencies of its own.
package csp_pkg;

    localparam int DATA_W  = 32;
    localparam int ROW_W   = 10;
    localparam int COUNT_W = 11;
    localparam int Q_W     = DATA_W + 1;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    localparam logic [1:0] STAGE_QUAD = 2'd0;
    localparam logic [1:0] STAGE_LIN  = 2'd1;
    localparam logic [1:0] STAGE_Y    = 2'd2;

    typedef struct packed {
        logic                     func;
        logic [ROW_W-1:0]         row_index;
        logic signed [DATA_W-1:0] knot_x;
        logic signed [DATA_W-1:0] knot_y;
        logic signed [DATA_W-1:0] coef_lin;
        logic signed [DATA_W-1:0] coef_quad;
        logic signed [DATA_W-1:0] coef_cub;
        logic signed [DATA_W-1:0] query_x;
    } spline_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] echo_x;
        logic signed [DATA_W-1:0] spline_y;
        logic [ROW_W-1:0]         segment;
        logic                     out_of_range;
        logic                     saturated;
    } spline_out_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] knot_y;
        logic signed [DATA_W-1:0] coef_lin;
        logic signed [DATA_W-1:0] coef_quad;
        logic signed [DATA_W-1:0] coef_cub;
    } coef_row_t;

    typedef struct packed {
        logic start;
        logic ack;
    } hor_ctrl_t;

    typedef struct packed {
        logic                     done;
        logic                     saturated;
        logic signed [DATA_W-1:0] value;
    } hor_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LAST,
        ST_FIRST,
        ST_DIR,
        ST_SEARCH,
        ST_FETCH,
        ST_EVAL
    } seq_state_t;

    typedef enum logic [1:0] {
        H_IDLE,
        H_MUL,
        H_ADD,
        H_DONE
    } hor_state_t;

endpackage

[hdl/cubic_spline_evaluator.sv]
// Top level of the piecewise cubic spline evaluator.
// Instantiates csp_knot_mem, csp_seq and csp_horner; uses csp_pkg.
//
// Usage:
//   The item channel (item_valid/item_ready/item) carries load and query beats.
//   A load beat (func = FUNC_LOAD) writes one knot row in the cycle it is
//   accepted and gives no result; a row at or above MAX_KNOTS is dropped.
//   A query beat (func = FUNC_EVAL) gives one beat on the result channel
//   (result_valid/result_ready/result).
//   cfg_write/cfg_data set knot_count; write it only while the block is idle.
// Sequence of a query:
//   A query reads the last and first knots, runs a binary search over the
//   abscissa memory with one read per cycle, fetches the row and runs three
//   Horner passes, each a multiply step and then an add step. item_ready is low
//   from acceptance of a query until its result is loaded into the output
//   register, so a query must finish before the next item is taken. Loads are
//   accepted back to back while the block is idle.
// Reset and stalls:
//   Reset clears the control state and sets knot_count to 2; the knot memories
//   are not cleared. A finished result waits in the output register while new
//   items are accepted; a second query then holds before delivery.
module cubic_spline_evaluator
    import csp_pkg::*;
#(
    parameter int MAX_KNOTS = 1024
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  spline_in_t         item,
    output logic               result_valid,
    input  logic               result_ready,
    output spline_out_t        result,
    input  logic               cfg_write,
    input  logic [COUNT_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_KNOTS);
    localparam int NW = AW + 1;
    localparam int EW = (NW > COUNT_W) ? NW : COUNT_W;

    logic [COUNT_W-1:0]       knot_count_reg;
    logic                     result_valid_reg;
    spline_out_t              result_reg;

    logic                     item_beat;
    logic [EW-1:0]            row_wide;
    logic                     wr_en;
    logic signed [DATA_W-1:0] x_rdata;
    logic [AW-1:0]            x_raddr;
    logic [AW-1:0]            row_raddr;
    coef_row_t                wr_row;
    coef_row_t                row_rdata;
    logic signed [Q_W-1:0]    q;
    hor_ctrl_t                hor_ctrl;
    hor_stat_t                hor_stat;
    logic                     load_ok;
    logic                     idle;
    logic                     out_load;
    spline_out_t              seq_result;

    assign item_ready       = idle;
    assign item_beat        = item_valid && idle;
    assign row_wide         = EW'(item.row_index);
    assign wr_en            = item_beat && (item.func == FUNC_LOAD) &&
                              (row_wide < EW'(MAX_KNOTS));
    assign wr_row.knot_y    = item.knot_y;
    assign wr_row.coef_lin  = item.coef_lin;
    assign wr_row.coef_quad = item.coef_quad;
    assign wr_row.coef_cub  = item.coef_cub;
    assign load_ok          = !result_valid_reg || result_ready;

    csp_knot_mem #(
        .DEPTH (MAX_KNOTS)
    ) u_mem (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (row_wide[AW-1:0]),
        .wr_x      (item.knot_x),
        .wr_row    (wr_row),
        .x_raddr   (x_raddr),
        .x_rdata   (x_rdata),
        .row_raddr (row_raddr),
        .row_rdata (row_rdata)
    );

    csp_seq #(
        .MAX_KNOTS (MAX_KNOTS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (item_beat && (item.func == FUNC_EVAL)),
        .query_x    (item.query_x),
        .knot_count (knot_count_reg),
        .x_rdata    (x_rdata),
        .x_raddr    (x_raddr),
        .row_raddr  (row_raddr),
        .q          (q),
        .hor_ctrl   (hor_ctrl),
        .hor_stat   (hor_stat),
        .load_ok    (load_ok),
        .idle       (idle),
        .out_load   (out_load),
        .result     (seq_result)
    );

    csp_horner u_horner (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (hor_ctrl),
        .q     (q),
        .coef  (row_rdata),
        .stat  (hor_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            knot_count_reg   <= COUNT_W'(2);
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                knot_count_reg <= cfg_data;
            end
            if (out_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            result_reg <= seq_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[hdl/csp_knot_mem.sv]
// Knot storage: one memory of abscissas and one of coefficient rows.
// One write port shared by both, one registered read port each. Uses csp_pkg.
module csp_knot_mem
    import csp_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  logic signed [DATA_W-1:0]  wr_x,
    input  coef_row_t                 wr_row,
    input  logic [$clog2(DEPTH)-1:0]  x_raddr,
    output logic signed [DATA_W-1:0]  x_rdata,
    input  logic [$clog2(DEPTH)-1:0]  row_raddr,
    output coef_row_t                 row_rdata
);

    logic [DATA_W-1:0] x_mem [0:DEPTH-1];
    coef_row_t         row_mem [0:DEPTH-1];

    logic [DATA_W-1:0] x_rd_reg;
    coef_row_t         row_rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            x_mem[wr_addr]   <= wr_x;
            row_mem[wr_addr] <= wr_row;
        end
        x_rd_reg   <= x_mem[x_raddr];
        row_rd_reg <= row_mem[row_raddr];
    end

    assign x_rdata   = x_rd_reg;
    assign row_rdata = row_rd_reg;

endmodule

[hdl/csp_horner.sv]
// Iterative Horner unit: three multiply and round-add-saturate passes.
// Each pass has a multiply step and an add step, with a register after the multiplier. Uses csp_pkg.
module csp_horner
    import csp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  hor_ctrl_t             ctrl,
    input  logic signed [Q_W-1:0] q,
    input  coef_row_t             coef,
    output hor_stat_t             stat
);

    localparam int SUM_W = 50;

    hor_state_t               state_reg, state_next;
    logic [1:0]               stage_reg, stage_next;
    logic signed [DATA_W-1:0] acc_reg, acc_next;
    logic [63:0]              prod_reg, prod_next;
    logic                     neg_reg, neg_next;
    logic                     sat_reg, sat_next;

    logic signed [DATA_W-1:0] acc_src;
    logic [DATA_W-1:0]        mag_acc;
    logic [Q_W-1:0]           mag_q;
    logic [64:0]              prod_full;
    logic [63:0]              rounded;
    logic [SUM_W-1:0]         mag_r;
    logic signed [SUM_W-1:0]  term;
    logic signed [DATA_W-1:0] coef_sel;
    logic signed [SUM_W-1:0]  sum;
    logic                     clip;

    always_comb
    begin
        acc_src   = (stage_reg == STAGE_QUAD) ? coef.coef_cub : acc_reg;
        mag_acc   = acc_src[DATA_W-1] ? (~acc_src + 1'b1) : acc_src;
        mag_q     = q[Q_W-1] ? (~q + 1'b1) : q;
        prod_full = mag_acc * mag_q;
        rounded   = prod_reg + 64'h8000;
        mag_r     = {2'b00, rounded[63:16]};
        term      = neg_reg ? -$signed(mag_r) : $signed(mag_r);
        case (stage_reg)
            STAGE_QUAD: coef_sel = coef.coef_quad;
            STAGE_LIN:  coef_sel = coef.coef_lin;
            default:    coef_sel = coef.knot_y;
        endcase
        sum  = term + {{(SUM_W-DATA_W){coef_sel[DATA_W-1]}}, coef_sel};
        clip = !((sum[SUM_W-1:DATA_W-1] == '0) || (sum[SUM_W-1:DATA_W-1] == '1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            stage_reg <= STAGE_QUAD;
            sat_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stage_reg <= stage_next;
            sat_reg   <= sat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        neg_reg  <= neg_next;
    end

    always_comb
    begin
        state_next = state_reg;
        stage_next = stage_reg;
        acc_next   = acc_reg;
        prod_next  = prod_reg;
        neg_next   = neg_reg;
        sat_next   = sat_reg;
        unique case (state_reg)
            H_IDLE:
            begin
                if (ctrl.start)
                begin
                    stage_next = STAGE_QUAD;
                    sat_next   = 1'b0;
                    state_next = H_MUL;
                end
            end
            H_MUL:
            begin
                prod_next  = prod_full[63:0];
                neg_next   = acc_src[DATA_W-1] ^ q[Q_W-1];
                state_next = H_ADD;
            end
            H_ADD:
            begin
                if (clip)
                begin
                    sat_next = 1'b1;
                    acc_next = sum[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                            : {1'b0, {(DATA_W-1){1'b1}}};
                end
                else
                begin
                    acc_next = sum[DATA_W-1:0];
                end
                if (stage_reg == STAGE_Y)
                begin
                    state_next = H_DONE;
                end
                else
                begin
                    stage_next = stage_reg + 2'd1;
                    state_next = H_MUL;
                end
            end
            H_DONE:
            begin
                if (ctrl.ack)
                begin
                    state_next = H_IDLE;
                end
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase
    end

    assign stat.done      = (state_reg == H_DONE);
    assign stat.saturated = sat_reg;
    assign stat.value     = acc_reg;

`ifndef ASSERT_OFF
    a_add_follows_mul: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == H_ADD |-> $past(state_reg) == H_MUL)
        else $error("Horner add pass without a preceding multiply.");
`endif

endmodule

[hdl/csp_seq.sv]
// Query sequencer: end-knot direction check, binary segment search over the
// abscissa memory, row fetch and Horner hand-off. Uses csp_pkg.
module csp_seq
    import csp_pkg::*;
#(
    parameter int MAX_KNOTS = 1024
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [DATA_W-1:0]      query_x,
    input  logic [COUNT_W-1:0]            knot_count,
    input  logic signed [DATA_W-1:0]      x_rdata,
    output logic [$clog2(MAX_KNOTS)-1:0]  x_raddr,
    output logic [$clog2(MAX_KNOTS)-1:0]  row_raddr,
    output logic signed [Q_W-1:0]         q,
    output hor_ctrl_t                     hor_ctrl,
    input  hor_stat_t                     hor_stat,
    input  logic                          load_ok,
    output logic                          idle,
    output logic                          out_load,
    output spline_out_t                   result
);

    localparam int AW = $clog2(MAX_KNOTS);
    localparam int NW = AW + 1;
    localparam int EW = (NW > COUNT_W) ? NW : COUNT_W;

    seq_state_t               state_reg, state_next;
    logic signed [DATA_W-1:0] x_reg, x_next;
    logic signed [DATA_W-1:0] last_reg, last_next;
    logic [NW-1:0]            n_reg, n_next;
    logic [NW-1:0]            lo_reg, lo_next;
    logic [NW-1:0]            hi_reg, hi_next;
    logic [AW-1:0]            mid_reg, mid_next;
    logic [AW-1:0]            seg_reg, seg_next;
    logic                     asc_reg, asc_next;
    logic                     oor_reg, oor_next;
    logic signed [Q_W-1:0]    q_reg, q_next;

    logic [EW-1:0]            count_wide;
    logic [EW-1:0]            n_wide;
    logic [NW-1:0]            n_last;
    logic                     pred;
    logic [NW-1:0]            mid_wide;
    logic [NW-1:0]            lo_step;
    logic [NW-1:0]            hi_step;
    logic [NW:0]              span_sum;
    logic [NW-1:0]            k_less;
    logic [AW-1:0]            seg_found;
    logic                     dir_asc;
    logic [EW-1:0]            seg_wide;

    always_comb
    begin
        count_wide = EW'(knot_count);
        if (count_wide < EW'(2))
        begin
            n_wide = EW'(2);
        end
        else if (count_wide > EW'(MAX_KNOTS))
        begin
            n_wide = EW'(MAX_KNOTS);
        end
        else
        begin
            n_wide = count_wide;
        end
        n_last    = n_reg - NW'(1);
        pred      = asc_reg ? (x_reg < x_rdata) : (x_reg > x_rdata);
        mid_wide  = NW'(mid_reg);
        lo_step   = pred ? lo_reg : (mid_wide + NW'(1));
        hi_step   = pred ? mid_wide : hi_reg;
        span_sum  = {1'b0, lo_step} + {1'b0, hi_step};
        k_less    = lo_step - NW'(1);
        seg_found = (lo_step == '0) ? '0 : k_less[AW-1:0];
        dir_asc   = (last_reg >= x_rdata);
        seg_wide  = EW'(seg_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= NW'(2);
            lo_reg    <= '0;
            hi_reg    <= NW'(1);
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        last_reg <= last_next;
        mid_reg  <= mid_next;
        seg_reg  <= seg_next;
        asc_reg  <= asc_next;
        oor_reg  <= oor_next;
        q_reg    <= q_next;
    end

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        last_next  = last_reg;
        n_next     = n_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        seg_next   = seg_reg;
        asc_next   = asc_reg;
        oor_next   = oor_reg;
        q_next     = q_reg;
        x_raddr    = mid_reg;
        hor_ctrl   = '0;
        out_load   = 1'b0;
        idle       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                idle = 1'b1;
                if (start)
                begin
                    x_next     = query_x;
                    n_next     = n_wide[NW-1:0];
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                x_raddr    = n_last[AW-1:0];
                state_next = ST_FIRST;
            end
            ST_FIRST:
            begin
                x_raddr    = '0;
                last_next  = x_rdata;
                state_next = ST_DIR;
            end
            ST_DIR:
            begin
                asc_next   = dir_asc;
                oor_next   = dir_asc ? (x_reg > last_reg) : (x_reg < last_reg);
                lo_next    = '0;
                hi_next    = n_reg;
                mid_next   = n_reg[AW:1];
                x_raddr    = n_reg[AW:1];
                state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (lo_step == hi_step)
                begin
                    seg_next   = seg_found;
                    oor_next   = oor_reg | (lo_step == '0);
                    x_raddr    = seg_found;
                    state_next = ST_FETCH;
                end
                else
                begin
                    lo_next  = lo_step;
                    hi_next  = hi_step;
                    mid_next = span_sum[AW:1];
                    x_raddr  = span_sum[AW:1];
                end
            end
            ST_FETCH:
            begin
                q_next         = {x_reg[DATA_W-1], x_reg} - {x_rdata[DATA_W-1], x_rdata};
                hor_ctrl.start = 1'b1;
                state_next     = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (hor_stat.done && load_ok)
                begin
                    out_load     = 1'b1;
                    hor_ctrl.ack = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign row_raddr           = seg_reg;
    assign q                   = q_reg;
    assign result.echo_x       = x_reg;
    assign result.spline_y     = hor_stat.value;
    assign result.segment      = seg_wide[ROW_W-1:0];
    assign result.out_of_range = oor_reg;
    assign result.saturated    = hor_stat.saturated;

`ifndef ASSERT_OFF
    a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SEARCH |-> (lo_reg < hi_reg) && (hi_reg <= n_reg))
        else $error("Segment search window is empty or exceeds the knot count.");

    a_segment_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FETCH |-> NW'(seg_reg) < n_reg)
        else $error("Selected segment lies beyond the rows in use.");

    a_load_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> hor_stat.done && load_ok)
        else $error("Result loaded before the Horner unit finished.");
`endif

endmodule
